// ----- src/ctlj_pkg.sv -----
// shared types and constants for the config text line joiner
// no dependencies; used by every module of the block and by the testbench
package ctlj_pkg;

  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;

  // result queue holds two beats of one item plus slack for the next ones
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    PhStart     = 3'd0,
    PhNormal    = 3'd1,
    PhComment   = 3'd2,
    PhAfterLe   = 3'd3,
    PhAfterPair = 3'd4,
    PhBlanks    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    phase_e     phase;
    logic       line_end_was_cr;
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

// ----- src/ctlj_in_if.sv -----
// input channel of the line joiner: valid/ready plus one raw text byte
// depends on nothing
interface ctlj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- src/ctlj_out_if.sv -----
// output channel of the line joiner: valid/ready plus one logical character
// depends on nothing
interface ctlj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_end;
  logic       last_of_run;

  modport source (output valid, output out_char, output is_end, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_char, input is_end, input last_of_run,
                  output ready);
endinterface

// ----- src/ctlj_step.sv -----
// per-byte decision logic: next phase and up to two results for one item
// depends on ctlj_pkg
module ctlj_step (
  input  ctlj_pkg::phase_e phase_i,
  input  logic             line_end_was_cr_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_input_i,
  output ctlj_pkg::step_t  step_o
);

  ctlj_pkg::phase_e nph;
  logic ncr;
  logic emit_nl, emit_b, emit_end, do_after, do_plain;
  logic is_le, is_blank, is_pair;
  logic [1:0] num;

  assign is_le    = (in_byte_i == ctlj_pkg::ChNewline) || (in_byte_i == ctlj_pkg::ChReturn);
  assign is_blank = (in_byte_i == ctlj_pkg::ChSpace) || (in_byte_i == ctlj_pkg::ChTab);
  assign is_pair  = (line_end_was_cr_i && (in_byte_i == ctlj_pkg::ChNewline)) ||
                    (!line_end_was_cr_i && (in_byte_i == ctlj_pkg::ChReturn));

  always_comb begin
    nph      = phase_i;
    ncr      = line_end_was_cr_i;
    emit_nl  = 1'b0;
    emit_b   = 1'b0;
    emit_end = 1'b0;
    do_after = 1'b0;
    do_plain = 1'b0;
    if (end_of_input_i) begin
      emit_nl  = (phase_i == ctlj_pkg::PhAfterLe) || (phase_i == ctlj_pkg::PhAfterPair) ||
                 (phase_i == ctlj_pkg::PhBlanks);
      emit_end = 1'b1;
      nph      = ctlj_pkg::PhStart;
      ncr      = 1'b0;
    end else begin
      case (phase_i)
        ctlj_pkg::PhStart: begin
          if (in_byte_i == ctlj_pkg::ChHash) nph = ctlj_pkg::PhComment;
          else do_plain = 1'b1;
        end
        ctlj_pkg::PhComment: begin
          if (is_le) begin
            nph = ctlj_pkg::PhAfterLe;
            ncr = (in_byte_i == ctlj_pkg::ChReturn);
          end
        end
        ctlj_pkg::PhAfterLe: begin
          if (is_pair) nph = ctlj_pkg::PhAfterPair;
          else do_after = 1'b1;
        end
        ctlj_pkg::PhAfterPair: begin
          do_after = 1'b1;
        end
        ctlj_pkg::PhBlanks: begin
          if (is_blank) begin
            nph = ctlj_pkg::PhBlanks;
          end else if (in_byte_i == ctlj_pkg::ChBackslash) begin
            nph = ctlj_pkg::PhNormal;
          end else begin
            emit_nl  = 1'b1;
            do_plain = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      // first byte after a complete line end, newline still pending
      if (do_after) begin
        if (in_byte_i == ctlj_pkg::ChHash) begin
          nph = ctlj_pkg::PhComment;
        end else if (is_blank) begin
          nph = ctlj_pkg::PhBlanks;
        end else if (in_byte_i == ctlj_pkg::ChBackslash) begin
          nph = ctlj_pkg::PhNormal;
        end else begin
          emit_nl  = 1'b1;
          do_plain = 1'b1;
        end
      end

      if (do_plain) begin
        if (is_le) begin
          nph = ctlj_pkg::PhAfterLe;
          ncr = (in_byte_i == ctlj_pkg::ChReturn);
        end else begin
          emit_b = 1'b1;
          nph    = ctlj_pkg::PhNormal;
        end
      end
    end
  end

  assign num = {1'b0, emit_nl} + {1'b0, emit_b} + {1'b0, emit_end};

  always_comb begin
    step_o.phase           = nph;
    step_o.line_end_was_cr = ncr;
    step_o.num             = num;
    step_o.res0.out_char   = emit_nl ? ctlj_pkg::ChNewline : (emit_b ? in_byte_i : 8'h00);
    step_o.res0.is_end     = !emit_nl && !emit_b && emit_end;
    step_o.res0.last_of_run = (num == 2'd1);
    step_o.res1.out_char   = emit_b ? in_byte_i : 8'h00;
    step_o.res1.is_end     = emit_end;
    step_o.res1.last_of_run = 1'b1;
  end

endmodule

// ----- src/ctlj_out_fifo.sv -----
// small result queue: takes up to two results a cycle, hands out one a beat
// depends on ctlj_pkg and ctlj_out_if
module ctlj_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_num_i,
  input  ctlj_pkg::result_t res0_i,
  input  ctlj_pkg::result_t res1_i,
  output logic              room_o,
  ctlj_out_if.source        out_o
);

  ctlj_pkg::result_t mem [ctlj_pkg::FifoDepth];
  logic [ctlj_pkg::PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [ctlj_pkg::CntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_q + ctlj_pkg::PtrW'(1);
  // room for a full item of two results, judged on the registered count
  assign room_o  = (cnt_q <= ctlj_pkg::CntW'(ctlj_pkg::FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + ctlj_pkg::PtrW'(push_num_i);
    rd_d  = pop ? rd_q + ctlj_pkg::PtrW'(1) : rd_q;
    cnt_d = cnt_q + ctlj_pkg::CntW'(push_num_i) - ctlj_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) mem[wr_q] <= res0_i;
    if (push_num_i == 2'd2) mem[wr_next] <= res1_i;
  end

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_char    = mem[rd_q].out_char;
  assign out_o.is_end      = mem[rd_q].is_end;
  assign out_o.last_of_run = mem[rd_q].last_of_run;

endmodule

// ----- src/config_text_line_joiner_core.sv -----
// Config text line joiner: drops comments, folds CR/LF pairs into one newline,
// strips leading blanks and joins backslash-continued lines. One input byte is
// taken per cycle while the result queue has room; an item goes input register
// -> decision logic -> result queue, and its results are registered in the
// queue before they leave. Items with a single result sustain one per cycle
// while the output is ready; an item that yields two results (pending newline
// plus a character, or newline plus end marker) needs two output beats, and the
// four-entry result queue stalls input when fewer than two free slots remain. No clearing pass after reset.
// depends on ctlj_pkg, ctlj_in_if, ctlj_out_if, ctlj_step, ctlj_out_fifo
module config_text_line_joiner_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctlj_in_if.sink   in_i,
  ctlj_out_if.source out_o
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             eoi_q;
  ctlj_pkg::phase_e phase_q, phase_d;
  logic             cr_q, cr_d;
  logic             room, advance, take;
  logic [1:0]       push_num;
  ctlj_pkg::step_t  step;

  assign advance    = in_valid_q && room;
  assign in_i.ready = !in_valid_q || room;
  assign take       = in_i.valid && in_i.ready;
  assign push_num   = advance ? step.num : 2'd0;

  always_comb begin
    in_valid_d = take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    phase_d    = advance ? step.phase : phase_q;
    cr_d       = advance ? step.line_end_was_cr : cr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= ctlj_pkg::PhStart;
      cr_q       <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      phase_q    <= phase_d;
      cr_q       <= cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= in_i.in_byte;
      eoi_q     <= in_i.end_of_input;
    end
  end

  ctlj_step u_step (
    .phase_i           (phase_q),
    .line_end_was_cr_i (cr_q),
    .in_byte_i         (in_byte_q),
    .end_of_input_i    (eoi_q),
    .step_o            (step)
  );

  ctlj_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .res0_i     (step.res0),
    .res1_i     (step.res1),
    .room_o     (room),
    .out_o      (out_o)
  );

endmodule

// ----- src/ctlj_checker.sv -----
// port-level checks on the line joiner output stream, bound to the top level
// depends on ctlj_pkg and config_text_line_joiner_core
module ctlj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       is_end_i,
  input logic       last_of_run_i
);

  // end marker always closes its item and carries no character
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> last_of_run_i && (out_char_i == 8'h00))
    else $error("end marker not last or char nonzero");

  // the only leading result of a two-result item is the pending newline
  a_first_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> (out_char_i == ctlj_pkg::ChNewline) && !is_end_i)
    else $error("non-final result is not a newline");

  // raw carriage returns never reach the output
  a_no_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i != ctlj_pkg::ChReturn))
    else $error("carriage return emitted");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) &&
    $stable(is_end_i) && $stable(last_of_run_i))
    else $error("stalled output beat changed");

endmodule

bind config_text_line_joiner_core ctlj_checker u_ctlj_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .is_end_i      (out_o.is_end),
  .last_of_run_i (out_o.last_of_run)
);

// ----- dv/testbench.sv -----
// self-checking testbench for config_text_line_joiner_core: random and directed text beats
// checked against an in-bench model of the comment, line-end and join filter
// depends on ctlj_pkg, ctlj_in_if, ctlj_out_if and the block itself
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } text_beat_t;

  localparam int unsigned MaxShown     = 10;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned EndWaitLimit = 20000;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       src_valid  = 1'b0;
  logic [7:0] src_byte   = 8'h00;
  logic       src_eoi    = 1'b0;
  logic       recv_ready = 1'b0;

  ctlj_in_if  in_bus ();
  ctlj_out_if out_bus ();

  assign in_bus.valid        = src_valid;
  assign in_bus.in_byte      = src_byte;
  assign in_bus.end_of_input = src_eoi;
  assign out_bus.ready       = recv_ready;

  config_text_line_joiner_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5ns clk_i = ~clk_i;

  text_beat_t           pending_beats[$];
  text_beat_t           beat_on_bus;
  ctlj_pkg::result_t    expected_chars[$];
  ctlj_pkg::result_t    step_chars[$];

  // model state of the filter
  ctlj_pkg::phase_e     model_phase = ctlj_pkg::PhStart;
  logic                 model_cr    = 1'b0;

  int unsigned beats_offered = 0;
  int unsigned beats_taken   = 0;
  int unsigned random_beats  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned ends_seen     = 0;
  int unsigned joins_seen    = 0;
  int unsigned comments_seen = 0;

  function automatic bit is_line_end(logic [7:0] b);
    return b == ctlj_pkg::ChNewline || b == ctlj_pkg::ChReturn;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == ctlj_pkg::ChSpace || b == ctlj_pkg::ChTab;
  endfunction

  function automatic void put_char(logic [7:0] ch, logic fin);
    ctlj_pkg::result_t r;
    r.out_char    = ch;
    r.is_end      = fin;
    r.last_of_run = 1'b0;
    step_chars.push_back(r);
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (is_line_end(b)) begin
      model_phase = ctlj_pkg::PhAfterLe;
      model_cr    = (b == ctlj_pkg::ChReturn);
    end else begin
      put_char(b, 1'b0);
      model_phase = ctlj_pkg::PhNormal;
    end
  endfunction

  // first byte once a whole line end is taken, newline still pending
  function automatic void after_line_end(logic [7:0] b);
    if (b == ctlj_pkg::ChHash) begin
      model_phase = ctlj_pkg::PhComment;
      comments_seen++;
    end else if (is_blank(b)) begin
      model_phase = ctlj_pkg::PhBlanks;
    end else if (b == ctlj_pkg::ChBackslash) begin
      model_phase = ctlj_pkg::PhNormal;
      joins_seen++;
    end else begin
      put_char(ctlj_pkg::ChNewline, 1'b0);
      plain_byte(b);
    end
  endfunction

  function automatic void filter_beat(text_beat_t t);
    int last;
    step_chars.delete();
    if (t.end_of_input) begin
      if (model_phase inside {ctlj_pkg::PhAfterLe, ctlj_pkg::PhAfterPair,
                              ctlj_pkg::PhBlanks})
        put_char(ctlj_pkg::ChNewline, 1'b0);
      put_char(8'h00, 1'b1);
      model_phase = ctlj_pkg::PhStart;
      model_cr    = 1'b0;
    end else begin
      case (model_phase)
        ctlj_pkg::PhStart: begin
          if (t.in_byte == ctlj_pkg::ChHash) begin
            model_phase = ctlj_pkg::PhComment;
            comments_seen++;
          end else begin
            plain_byte(t.in_byte);
          end
        end
        ctlj_pkg::PhComment: begin
          if (is_line_end(t.in_byte)) begin
            model_phase = ctlj_pkg::PhAfterLe;
            model_cr    = (t.in_byte == ctlj_pkg::ChReturn);
          end
        end
        ctlj_pkg::PhAfterLe: begin
          // the other line-end byte completes a cr/lf pair
          if ((model_cr && t.in_byte == ctlj_pkg::ChNewline) ||
              (!model_cr && t.in_byte == ctlj_pkg::ChReturn))
            model_phase = ctlj_pkg::PhAfterPair;
          else
            after_line_end(t.in_byte);
        end
        ctlj_pkg::PhAfterPair: after_line_end(t.in_byte);
        ctlj_pkg::PhBlanks: begin
          if (is_blank(t.in_byte)) begin
          end else if (t.in_byte == ctlj_pkg::ChBackslash) begin
            model_phase = ctlj_pkg::PhNormal;
            joins_seen++;
          end else begin
            put_char(ctlj_pkg::ChNewline, 1'b0);
            plain_byte(t.in_byte);
          end
        end
        default: plain_byte(t.in_byte);
      endcase
    end
    if (step_chars.size() != 0) begin
      last = step_chars.size() - 1;
      step_chars[last].last_of_run = 1'b1;
    end
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endfunction

  // stimulus generation

  task automatic add_beat(logic [7:0] b, logic eoi, bit counted);
    text_beat_t t;
    t.in_byte      = b;
    t.end_of_input = eoi;
    pending_beats.push_back(t);
    if (counted) random_beats++;
  endtask

  function automatic logic [7:0] text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return ctlj_pkg::ChHash;
    if (r < 12) return ctlj_pkg::ChBackslash;
    if (r < 18) return ctlj_pkg::ChSpace;
    if (r < 22) return ctlj_pkg::ChTab;
    if (r < 32) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic add_line_end();
    case ($urandom_range(0, 5))
      0: add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b1);
      1: add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b1);
      2: begin
        add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b1);
        add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b1);
      end
      3: begin
        add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b1);
        add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b1);
      end
      4: begin
        add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b1);
        add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b1);
      end
      default: begin
        add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b1);
        add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b1);
      end
    endcase
  endtask

  // a few lines of config-like text, mostly closed by an end beat
  task automatic add_stream();
    int unsigned lines;
    int unsigned n;
    lines = $urandom_range(1, 6);
    for (int unsigned i = 0; i < lines; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_beat(ctlj_pkg::ChHash, 1'b0, 1'b1);
        n = $urandom_range(0, 8);
        repeat (n) add_beat(8'($urandom_range(32, 126)), 1'b0, 1'b1);
      end else begin
        n = $urandom_range(0, 3);
        repeat (n)
          add_beat($urandom_range(0, 1) ? ctlj_pkg::ChSpace : ctlj_pkg::ChTab, 1'b0, 1'b1);
        if ($urandom_range(0, 3) == 0) add_beat(ctlj_pkg::ChBackslash, 1'b0, 1'b1);
        n = $urandom_range(0, 12);
        repeat (n) add_beat(text_char(), 1'b0, 1'b1);
      end
      if (i < lines - 1 || $urandom_range(0, 1) == 1) add_line_end();
    end
    if ($urandom_range(0, 99) < 85) add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic add_noise();
    int unsigned n;
    n = $urandom_range(1, 10);
    repeat (n) add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b1);
  endtask

  task automatic fill_random(int unsigned upto);
    while (random_beats < upto) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_stream();
    end
  endtask

  task automatic wait_all_done();
    while (pending_beats.size() != 0 || beats_offered != beats_taken ||
           expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // driver: one beat held on the bus until taken
  always @(negedge clk_i) begin
    if (rst_ni && beats_offered == beats_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat_on_bus = pending_beats.pop_front();
        beats_offered++;
        src_valid <= 1'b1;
        src_byte  <= beat_on_bus.in_byte;
        src_eoi   <= beat_on_bus.end_of_input;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && src_valid && in_bus.ready) begin
      filter_beat(beat_on_bus);
      beats_taken++;
    end
  end

  always @(negedge clk_i) begin
    recv_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic bit count_mismatch();
    mismatches++;
    return mismatches <= MaxShown;
  endfunction

  // monitor
  always @(posedge clk_i) begin
    ctlj_pkg::result_t got;
    ctlj_pkg::result_t want;
    if (rst_ni && out_bus.valid && recv_ready) begin
      got.out_char    = out_bus.out_char;
      got.is_end      = out_bus.is_end;
      got.last_of_run = out_bus.last_of_run;
      results_seen++;
      if (got.is_end === 1'b1) ends_seen++;
      if (expected_chars.size() == 0) begin
        if (count_mismatch())
          $display("%0t: unexpected beat char %02h end %0b last %0b", $realtime,
                   got.out_char, got.is_end, got.last_of_run);
      end else begin
        want = expected_chars.pop_front();
        if (got.out_char !== want.out_char || got.is_end !== want.is_end ||
            got.last_of_run !== want.last_of_run) begin
          if (count_mismatch())
            $display({"%0t: mismatch, expected char %02h end %0b last %0b, ",
                      "got char %02h end %0b last %0b"},
                     $realtime, want.out_char, want.is_end, want.last_of_run,
                     got.out_char, got.is_end, got.last_of_run);
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 65;

    // comment at stream start, closed by an lf cr pair as its line end
    add_beat(ctlj_pkg::ChHash, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b0);
    // text, cr lf pair, leading blanks, then a hash that is plain text
    add_beat(8'h61, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChSpace, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChTab, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChHash, 1'b0, 1'b0);
    // joined line, hash right after the backslash, extreme byte values
    add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChBackslash, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChHash, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    // pending newline met by another line end, then by a plain byte
    add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChNewline, 1'b0, 1'b0);
    add_beat(8'h62, 1'b0, 1'b0);
    // end right after a join through blanks, byte field ignored
    add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChSpace, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChBackslash, 1'b0, 1'b0);
    add_beat(8'hA5, 1'b1, 1'b0);
    // end inside a comment, end at stream start, end with newline pending
    add_beat(ctlj_pkg::ChHash, 1'b0, 1'b0);
    add_beat(8'h7A, 1'b1, 1'b0);
    add_beat(8'h5A, 1'b1, 1'b0);
    add_beat(8'h71, 1'b0, 1'b0);
    add_beat(ctlj_pkg::ChReturn, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);

    fill_random(233);
    // sender holds off until everything is out
    wait_all_done();

    send_idle_pct = 65;
    recv_idle_pct = 38;
    fill_random(467);
    wait_all_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(700);

    while (pending_beats.size() != 0 || beats_offered != beats_taken) @(posedge clk_i);
    waited = 0;
    while (expected_chars.size() != 0 && waited < EndWaitLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (waited >= EndWaitLimit) begin
      $display("timed out waiting for %0d characters", expected_chars.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      repeat (DrainCycles) @(posedge clk_i);
      $display("%0d text beats in, %0d output beats checked, %0d stream ends",
               beats_taken, results_seen, ends_seen);
      $display("%0d comments dropped, %0d lines joined, %0d mismatches, %0d left over",
               comments_seen, joins_seen, mismatches, expected_chars.size());
      if (mismatches == 0 && expected_chars.size() == 0)
        $display("testbench OK");
      else
        $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    #2ms;
    $display("run timed out");
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- config_text_line_joiner_core.f -----
src/ctlj_pkg.sv
src/ctlj_in_if.sv
src/ctlj_out_if.sv
src/ctlj_step.sv
src/ctlj_out_fifo.sv
src/config_text_line_joiner_core.sv
src/ctlj_checker.sv
dv/testbench.sv
